@@ hdl/mems_pkg.sv @@
package mems_pkg;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_EXPLORE = 3'd1,
    PH_RETURN  = 3'd2,
    PH_SPEED   = 3'd3,
    PH_DONE    = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    ST_PLAN     = 2'd0,
    ST_APPROACH = 2'd1,
    ST_TURN     = 2'd2,
    ST_MOVE     = 2'd3
  } step_e;

  typedef enum logic [2:0] {
    CMD_NONE     = 3'd0,
    CMD_FORWARD  = 3'd1,
    CMD_APPROACH = 3'd2,
    CMD_RIGHT    = 3'd3,
    CMD_LEFT     = 3'd4,
    CMD_AROUND   = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    MAP_NONE   = 2'd0,
    MAP_GOAL   = 2'd1,
    MAP_RETURN = 2'd2,
    MAP_PESS   = 2'd3
  } map_e;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_BEGIN = 1'b1
  } op_e;

  typedef enum logic {
    REG_SPEED_RUN_EN    = 1'b0,
    REG_APPROACH_ENABLE = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic       op;
    logic       motion_busy;
    logic [1:0] heading;
    logic       at_goal;
    logic       at_start;
    logic [1:0] dir_explore;
    logic [1:0] dir_return;
    logic [1:0] dir_speed;
  } item_t;

  typedef struct packed {
    cmd_e   command;
    phase_e phase_now;
    map_e   map_request;
    logic   record_walls;
    logic   clear_map;
  } result_t;

  typedef struct packed {
    phase_e     phase;
    step_e      step;
    logic [1:0] target_heading;
  } state_t;

  typedef struct packed {
    logic speed_run_en;
    logic approach_enable;
  } cfg_t;

endpackage

@@ hdl/maze_explore_move_sequencer.sv @@
// Move sequencer for a maze-exploring robot. One item (a begin event or a
// tick) is accepted per clock cycle with no bubbles while the result side
// does not stall; each item yields exactly one result item through the input
// register, one pass of the step logic and the result register. The
// phase/step state from that pass is committed as the item enters the result
// register. Backpressure on the result side stalls the input side through the
// same two registers. Configuration writes are always ready and take effect
// on the next cycle; write them only while no item is in flight.
module maze_explore_move_sequencer (
  input  logic       clk_i,
  input  logic       rst_ni,

  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       op_i,
  input  logic       motion_busy_i,
  input  logic [1:0] heading_i,
  input  logic       at_goal_i,
  input  logic       at_start_i,
  input  logic [1:0] dir_explore_i,
  input  logic [1:0] dir_return_i,
  input  logic [1:0] dir_speed_i,

  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] command_o,
  output logic [2:0] phase_now_o,
  output logic [1:0] map_request_o,
  output logic       record_walls_o,
  output logic       clear_map_o,

  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_index_i,
  input  logic       cfg_data_i
);

  mems_pkg::cfg_t    cfg;
  mems_pkg::item_t   item_q;
  mems_pkg::state_t  state_q, state_d;
  mems_pkg::result_t res_q, res_d;
  logic              item_valid_q;
  logic              out_valid_q;
  logic              adv;
  logic              in_take;

  mems_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  mems_step_logic u_step (
    .item_i   (item_q),
    .state_i  (state_q),
    .cfg_i    (cfg),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // registered item moves into the result register when that one is free
  assign adv        = item_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = item_valid_q && !adv;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q         <= 1'b0;
      out_valid_q          <= 1'b0;
      state_q.phase        <= mems_pkg::PH_IDLE;
      state_q.step         <= mems_pkg::ST_PLAN;
      state_q.target_heading <= 2'd0;
    end else begin
      if (in_take) begin
        item_valid_q <= 1'b1;
      end else if (adv) begin
        item_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q <= '{op:          op_i,
                  motion_busy: motion_busy_i,
                  heading:     heading_i,
                  at_goal:     at_goal_i,
                  at_start:    at_start_i,
                  dir_explore: dir_explore_i,
                  dir_return:  dir_return_i,
                  dir_speed:   dir_speed_i};
    end
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign command_o      = res_q.command;
  assign phase_now_o    = res_q.phase_now;
  assign map_request_o  = res_q.map_request;
  assign record_walls_o = res_q.record_walls;
  assign clear_map_o    = res_q.clear_map;

endmodule

@@ hdl/mems_cfg_regs.sv @@
module mems_cfg_regs (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic               cfg_data_i,
  output mems_pkg::cfg_t     cfg_o
);

  mems_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (mems_pkg::reg_idx_e'(cfg_index_i))
        mems_pkg::REG_SPEED_RUN_EN:    cfg_d.speed_run_en    = cfg_data_i;
        mems_pkg::REG_APPROACH_ENABLE: cfg_d.approach_enable = cfg_data_i;
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.speed_run_en    <= 1'b0;
      cfg_q.approach_enable <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ hdl/mems_step_logic.sv @@
module mems_step_logic (
  input  mems_pkg::item_t   item_i,
  input  mems_pkg::state_t  state_i,
  input  mems_pkg::cfg_t    cfg_i,
  output mems_pkg::state_t  state_o,
  output mems_pkg::result_t result_o
);

  // quarter turns from heading to target, mod 4; zero and two both pivot around
  function automatic mems_pkg::cmd_e pivot_cmd(input logic [1:0] diff);
    mems_pkg::cmd_e c;
    unique case (diff)
      2'd1:    c = mems_pkg::CMD_RIGHT;
      2'd3:    c = mems_pkg::CMD_LEFT;
      default: c = mems_pkg::CMD_AROUND;
    endcase
    return c;
  endfunction

  logic       active;
  logic       stop;
  logic [1:0] dir;
  logic [1:0] plan_diff;
  logic [1:0] pivot_diff;

  assign active     = (state_i.phase != mems_pkg::PH_IDLE) &&
                      (state_i.phase != mems_pkg::PH_DONE);
  assign pivot_diff = state_i.target_heading - item_i.heading;

  always_comb begin
    state_o  = state_i;
    result_o = '{command:      mems_pkg::CMD_NONE,
                 phase_now:    mems_pkg::PH_IDLE,
                 map_request:  mems_pkg::MAP_NONE,
                 record_walls: 1'b0,
                 clear_map:    1'b0};
    stop      = 1'b0;
    dir       = item_i.dir_speed;
    plan_diff = '0;

    if (mems_pkg::op_e'(item_i.op) == mems_pkg::OP_BEGIN) begin
      state_o.phase      = mems_pkg::PH_EXPLORE;
      state_o.step       = mems_pkg::ST_PLAN;
      result_o.clear_map = 1'b1;
    end else if (active && !item_i.motion_busy) begin
      unique case (state_i.step)
        mems_pkg::ST_APPROACH: begin
          result_o.command = pivot_cmd(pivot_diff);
          state_o.step     = mems_pkg::ST_TURN;
        end
        mems_pkg::ST_TURN: begin
          result_o.command = mems_pkg::CMD_FORWARD;
          state_o.step     = mems_pkg::ST_MOVE;
        end
        mems_pkg::ST_MOVE: begin
          state_o.step = mems_pkg::ST_PLAN;
        end
        default: begin
          result_o.record_walls = 1'b1;
          // arrival handling first; planning then uses the updated phase
          if (state_i.phase == mems_pkg::PH_EXPLORE && item_i.at_goal) begin
            if (!cfg_i.speed_run_en) begin
              state_o.phase = mems_pkg::PH_DONE;
              stop          = 1'b1;
            end else begin
              state_o.phase = mems_pkg::PH_RETURN;
            end
          end else if (state_i.phase == mems_pkg::PH_RETURN && item_i.at_start) begin
            state_o.phase = mems_pkg::PH_SPEED;
          end else if (state_i.phase == mems_pkg::PH_SPEED && item_i.at_goal) begin
            state_o.phase = mems_pkg::PH_DONE;
            stop          = 1'b1;
          end

          if (!stop) begin
            priority if (state_o.phase == mems_pkg::PH_EXPLORE) begin
              result_o.map_request = mems_pkg::MAP_GOAL;
              dir                  = item_i.dir_explore;
            end else if (state_o.phase == mems_pkg::PH_RETURN) begin
              result_o.map_request = mems_pkg::MAP_RETURN;
              dir                  = item_i.dir_return;
            end else begin
              result_o.map_request = mems_pkg::MAP_PESS;
              dir                  = item_i.dir_speed;
            end
            state_o.target_heading = dir;
            plan_diff              = dir - item_i.heading;
            priority if (plan_diff == 2'd0) begin
              result_o.command = mems_pkg::CMD_FORWARD;
              state_o.step     = mems_pkg::ST_MOVE;
            end else if (cfg_i.approach_enable) begin
              result_o.command = mems_pkg::CMD_APPROACH;
              state_o.step     = mems_pkg::ST_APPROACH;
            end else begin
              result_o.command = pivot_cmd(plan_diff);
              state_o.step     = mems_pkg::ST_TURN;
            end
          end
        end
      endcase
    end

    result_o.phase_now = state_o.phase;
  end

endmodule
